/* design/vmos_pkg.sv */
// ----------------------------------------------------------------------------
// vmos_pkg
// Shared types and constants of the operand stack and locals block: sizes,
// operation and status codes, controller states and the command bundle.
// ----------------------------------------------------------------------------
package vmos_pkg;

    // Storage sizes.
    localparam int STACK_DEPTH  = 256;
    localparam int LOCALS_DEPTH = 256;
    localparam int STACK_AW     = $clog2(STACK_DEPTH);
    localparam int LOCAL_AW     = $clog2(LOCALS_DEPTH);
    localparam int WORD_W       = 32;

    // Field widths of the item and result.
    localparam int FUNC_W   = 4;
    localparam int INDEX_W  = 8;
    localparam int STATUS_W = 2;
    localparam int DEPTH_W  = 8;
    localparam int LCOUNT_W = 9;

    // Operation codes.
    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH       = 4'd0,
        FN_POP        = 4'd1,
        FN_TOP        = 4'd2,
        FN_STORE_LOC  = 4'd3,
        FN_PUSH_LOC   = 4'd4,
        FN_SET_LOC    = 4'd5,
        FN_GET_LOC    = 4'd6,
        FN_READ_SLOT  = 4'd7,
        FN_WRITE_SLOT = 4'd8
    } func_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_UNDER   = 2'd1,
        ST_OVER    = 2'd2,
        ST_NOLOCAL = 2'd3
    } status_t;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_OUT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic exec;
    } cmd_t;

endpackage

/* design/vmos_ram.sv */
// ----------------------------------------------------------------------------
// vmos_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module vmos_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/vmos_ctrl.sv */
// ----------------------------------------------------------------------------
// vmos_ctrl
// Controller of the operand stack block: takes an item, lets the datapath
// execute it once the memory reads are back, then offers the result.
// ----------------------------------------------------------------------------
module vmos_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  logic           m_tready,
    output vmos_pkg::cmd_t cmd
);

    vmos_pkg::state_t state_reg;
    vmos_pkg::state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vmos_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and command outputs.
    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            vmos_pkg::S_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = vmos_pkg::S_EXEC;
                end
            end
            vmos_pkg::S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = vmos_pkg::S_OUT;
            end
            vmos_pkg::S_OUT:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    state_next = vmos_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = vmos_pkg::S_IDLE;
            end
        endcase
    end

endmodule

/* design/vmos_dpath.sv */
// ----------------------------------------------------------------------------
// vmos_dpath
// Datapath of the operand stack block: the stack and locals memories, the
// stack count, the local count register, the item latch and the result
// registers.
// ----------------------------------------------------------------------------
module vmos_dpath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  vmos_pkg::cmd_t                      cmd,
    input  logic [vmos_pkg::FUNC_W-1:0]         in_func,
    input  logic [vmos_pkg::INDEX_W-1:0]        in_index,
    input  logic [vmos_pkg::WORD_W-1:0]         in_value,
    input  logic                                local_count_we,
    input  logic [vmos_pkg::LCOUNT_W-1:0]       local_count_wdata,
    output logic [vmos_pkg::WORD_W-1:0]         out_data,
    output logic [vmos_pkg::STATUS_W-1:0]       out_status,
    output logic [vmos_pkg::DEPTH_W-1:0]        out_depth
);

    // Latched item.
    vmos_pkg::func_t                     func_reg;
    logic [vmos_pkg::INDEX_W-1:0]        index_reg;
    logic [vmos_pkg::WORD_W-1:0]         value_reg;

    // Architectural state.
    logic [vmos_pkg::STACK_AW-1:0]       count_reg;
    logic [vmos_pkg::STACK_AW-1:0]       count_next;
    logic [vmos_pkg::LCOUNT_W-1:0]       local_count_reg;

    // Result registers.
    logic [vmos_pkg::WORD_W-1:0]         data_reg;
    logic [vmos_pkg::WORD_W-1:0]         data_next;
    vmos_pkg::status_t                   status_reg;
    vmos_pkg::status_t                   status_next;

    // Memory ports.
    logic                                stk_we;
    logic [vmos_pkg::STACK_AW-1:0]       stk_waddr;
    logic [vmos_pkg::WORD_W-1:0]         stk_wdata;
    logic [vmos_pkg::STACK_AW-1:0]       stk_raddr;
    logic [vmos_pkg::WORD_W-1:0]         stk_rdata;
    logic                                loc_we;
    logic [vmos_pkg::WORD_W-1:0]         loc_wdata;
    logic [vmos_pkg::LOCAL_AW-1:0]       loc_addr;
    logic [vmos_pkg::LOCAL_AW-1:0]       loc_raddr;
    logic [vmos_pkg::WORD_W-1:0]         loc_rdata;

    // Checks on the latched item.
    logic                                local_ok;
    logic                                stack_full;
    logic                                stack_empty;

    // Read addresses are formed from the incoming item so that the read
    // data is ready in the execute cycle.
    always_comb
    begin
        if (vmos_pkg::func_t'(in_func) == vmos_pkg::FN_READ_SLOT)
        begin
            stk_raddr = vmos_pkg::STACK_AW'(in_index);
        end
        else
        begin
            stk_raddr = count_reg - vmos_pkg::STACK_AW'(1);
        end
        loc_raddr = vmos_pkg::LOCAL_AW'(in_index);
    end

    // Item latch.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            func_reg  <= vmos_pkg::func_t'(in_func);
            index_reg <= in_index;
            value_reg <= in_value;
        end
    end

    assign loc_addr    = vmos_pkg::LOCAL_AW'(index_reg);
    assign local_ok    = ({1'b0, index_reg} < local_count_reg)
                         && (32'(index_reg) < vmos_pkg::LOCALS_DEPTH);
    assign stack_full  = count_reg >= vmos_pkg::STACK_AW'(vmos_pkg::STACK_DEPTH - 1);
    assign stack_empty = count_reg == '0;

    // Execute: checks, memory writes, next count and result.
    always_comb
    begin
        count_next  = count_reg;
        data_next   = '0;
        status_next = vmos_pkg::ST_OK;
        stk_we      = 1'b0;
        stk_waddr   = count_reg;
        stk_wdata   = value_reg;
        loc_we      = 1'b0;
        loc_wdata   = value_reg;
        unique case (func_reg)
            vmos_pkg::FN_PUSH:
            begin
                if (stack_full)
                begin
                    status_next = vmos_pkg::ST_OVER;
                end
                else
                begin
                    stk_we     = 1'b1;
                    count_next = count_reg + vmos_pkg::STACK_AW'(1);
                end
            end
            vmos_pkg::FN_POP:
            begin
                if (stack_empty)
                begin
                    status_next = vmos_pkg::ST_UNDER;
                end
                else
                begin
                    data_next  = stk_rdata;
                    count_next = count_reg - vmos_pkg::STACK_AW'(1);
                end
            end
            vmos_pkg::FN_TOP:
            begin
                if (stack_empty)
                begin
                    status_next = vmos_pkg::ST_UNDER;
                end
                else
                begin
                    data_next = stk_rdata;
                end
            end
            vmos_pkg::FN_STORE_LOC:
            begin
                if (!local_ok)
                begin
                    status_next = vmos_pkg::ST_NOLOCAL;
                end
                else if (stack_empty)
                begin
                    status_next = vmos_pkg::ST_UNDER;
                end
                else
                begin
                    data_next  = stk_rdata;
                    loc_we     = 1'b1;
                    loc_wdata  = stk_rdata;
                    count_next = count_reg - vmos_pkg::STACK_AW'(1);
                end
            end
            vmos_pkg::FN_PUSH_LOC:
            begin
                if (!local_ok)
                begin
                    status_next = vmos_pkg::ST_NOLOCAL;
                end
                else if (stack_full)
                begin
                    status_next = vmos_pkg::ST_OVER;
                end
                else
                begin
                    data_next  = loc_rdata;
                    stk_we     = 1'b1;
                    stk_wdata  = loc_rdata;
                    count_next = count_reg + vmos_pkg::STACK_AW'(1);
                end
            end
            vmos_pkg::FN_SET_LOC:
            begin
                if (!local_ok)
                begin
                    status_next = vmos_pkg::ST_NOLOCAL;
                end
                else
                begin
                    loc_we = 1'b1;
                end
            end
            vmos_pkg::FN_GET_LOC:
            begin
                if (!local_ok)
                begin
                    status_next = vmos_pkg::ST_NOLOCAL;
                end
                else
                begin
                    data_next = loc_rdata;
                end
            end
            vmos_pkg::FN_READ_SLOT:
            begin
                data_next = stk_rdata;
            end
            vmos_pkg::FN_WRITE_SLOT:
            begin
                stk_we    = 1'b1;
                stk_waddr = vmos_pkg::STACK_AW'(index_reg);
            end
            default:
            begin
                // Unused operation codes do nothing.
                data_next = '0;
            end
        endcase
        if (!cmd.exec)
        begin
            stk_we = 1'b0;
            loc_we = 1'b0;
        end
    end

    // Stack count and local count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= '0;
            local_count_reg <= '0;
        end
        else
        begin
            if (cmd.exec)
            begin
                count_reg <= count_next;
            end
            if (local_count_we)
            begin
                local_count_reg <= local_count_wdata;
            end
        end
    end

    // Result registers, held until the result is taken.
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            data_reg   <= data_next;
            status_reg <= status_next;
        end
    end

    // Operand stack memory.
    vmos_ram #(
        .WIDTH (vmos_pkg::WORD_W),
        .DEPTH (vmos_pkg::STACK_DEPTH)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (cmd.accept),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    // Local variable memory.
    vmos_ram #(
        .WIDTH (vmos_pkg::WORD_W),
        .DEPTH (vmos_pkg::LOCALS_DEPTH)
    ) u_local_ram (
        .clk   (clk),
        .we    (loc_we),
        .waddr (loc_addr),
        .wdata (loc_wdata),
        .re    (cmd.accept),
        .raddr (loc_raddr),
        .rdata (loc_rdata)
    );

    assign out_data   = data_reg;
    assign out_status = status_reg;
    assign out_depth  = vmos_pkg::DEPTH_W'(count_reg);

endmodule

/* design/vm_operand_stack_and_locals.sv */
// ----------------------------------------------------------------------------
// vm_operand_stack_and_locals
// Operand stack and local variable store of a stack machine frame.
//
// Usage: one item on the slave stream names one operation (push, pop, top,
// store local, push local, set local, get local, read slot, write slot) in
// s_tuser, with its index and value in s_tdata. Every item gives exactly one
// result on the master stream: the data word and the depth after the
// operation in m_tdata, the status code in m_tuser. A failing operation
// leaves all state unchanged. local_count_we writes the number of valid
// locals; write it only while the block is idle.
// Flow: an item is executed in the cycle after it is accepted, once the
// registered reads of the stack and locals memories return, and its result
// is valid in the cycle after that. One item at a time is in flight: no new
// item is accepted until the result of the last one has been taken.
// Reset clears the stack count and the local count; memory contents stay
// undefined until written. When the receiver stalls, the result is held in
// m_tdata and m_tuser and s_tready stays low until it is taken.
// ----------------------------------------------------------------------------
module vm_operand_stack_and_locals (
    input  logic        clk,
    input  logic        rst_n,
    // Item stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [7:0] index, [39:8] value
    input  logic [3:0]  s_tuser,   // [3:0] func
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] data, [39:32] depth
    output logic [1:0]  m_tuser,   // [1:0] status
    // Local count register.
    input  logic        local_count_we,
    input  logic [8:0]  local_count_wdata
);

    vmos_pkg::cmd_t                  cmd;
    logic [vmos_pkg::WORD_W-1:0]     res_data;
    logic [vmos_pkg::STATUS_W-1:0]   res_status;
    logic [vmos_pkg::DEPTH_W-1:0]    res_depth;

    // Handshake control.
    vmos_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // Stack, locals and result registers.
    vmos_dpath u_dpath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .in_func           (s_tuser),
        .in_index          (s_tdata[7:0]),
        .in_value          (s_tdata[39:8]),
        .local_count_we    (local_count_we),
        .local_count_wdata (local_count_wdata),
        .out_data          (res_data),
        .out_status        (res_status),
        .out_depth         (res_depth)
    );

    assign m_tdata = {res_depth, res_data};
    assign m_tuser = res_status;

endmodule
